@@ sv/ptbm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptbm_pkg
// shared constants, codes and control types of the 2M block table mapper
// ----------------------------------------------------------------------------
package ptbm_pkg;

  localparam int NUM_PAGES = 32;
  localparam int SLOTS     = 512;
  localparam int MAX_RUN   = 512;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int ADDR_W  = PAGE_W + SLOT_W;
  localparam int PAGES_W = $clog2(NUM_PAGES + 1);
  localparam int CNT_W   = 10;
  localparam int VA_W    = 48;
  localparam int OA_W    = 36;

  localparam logic [63:0]   ATTR_MASK = 64'hfff0_0000_0000_0ffc;
  localparam logic [VA_W-1:0] STEP_2M = 48'h0000_0020_0000;

  typedef enum logic [0:0] {
    CMD_MAP  = 1'b0,
    CMD_READ = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    SC_OK          = 3'd0,
    SC_VA_MISALIGN = 3'd1,
    SC_PA_MISALIGN = 3'd2,
    SC_NO_PAGE     = 3'd3,
    SC_CONFLICT    = 3'd4
  } stat_code_t;

  typedef enum logic [3:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_DATA,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_ALLOC_CLR,
    ST_ALLOC_LINK,
    ST_BLK_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       rd_entry;
    logic       rd_walk;
    logic       alloc_start;
    logic       clr_wr;
    logic       link_wr;
    logic       descend_rd;
    logic       descend_link;
    logic       blk_wr;
    logic       set_status;
    stat_code_t code;
    logic       set_read_data;
    logic       out_load;
  } ptbm_cmd_t;

  typedef struct packed {
    logic is_read;
    logic va_mis;
    logic pa_mis;
    logic run_empty;
    logic ent_valid;
    logic ent_table;
    logic next_ok;
    logic at_level1;
    logic store_full;
    logic clr_last;
    logic run_last;
    logic out_free;
  } ptbm_stat_t;

endpackage

@@ sv/ptbm_if.sv @@
// ----------------------------------------------------------------------------
// ptbm request and response channels
// valid/ready channels carrying the command word and the result word
// ----------------------------------------------------------------------------
interface ptbm_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [47:0] virt_addr;
  logic [47:0] phys_addr;
  logic [9:0]  block_count;
  logic [63:0] attributes;
  logic [4:0]  read_page;
  logic [8:0]  read_slot;

  modport source (
    output valid, cmd, virt_addr, phys_addr, block_count, attributes, read_page,
           read_slot,
    input  ready
  );
  modport sink (
    input  valid, cmd, virt_addr, phys_addr, block_count, attributes, read_page,
           read_slot,
    output ready
  );
endinterface

interface ptbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry_data;
  logic [5:0]  pages_used;

  modport source (
    output valid, status, entry_data, pages_used,
    input  ready
  );
  modport sink (
    input  valid, status, entry_data, pages_used,
    output ready
  );
endinterface

@@ sv/page_table_2m_block_mapper_core.sv @@
// ----------------------------------------------------------------------------
// page_table_2m_block_mapper_core
// builds 4K granule translation tables with 2M block entries in a local store
// ----------------------------------------------------------------------------
// req carries one command word: a map of block_count 2M blocks starting at
// virt_addr/phys_addr, or a read of one stored entry (read_page, read_slot).
// rsp returns one word per command: status, entry_data and pages_used.
// table_base is written over the APB port at byte address 0 (64-bit data).
// After reset the root page is swept to zero, one entry a cycle; req.ready
// stays low until the sweep is done.
// Commands run one at a time through the table store. A map walks the
// table levels for each block and writes its block entry; every table
// page it allocates is cleared entry by entry through the store port. A
// misaligned or empty map goes straight to its result. A result is held
// in an output register: the next command is accepted while it waits,
// and a finished command waits only when the previous result has not
// yet been taken.
// ----------------------------------------------------------------------------
module page_table_2m_block_mapper_core import ptbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ptbm_req_if.sink    req,
  ptbm_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0] table_base;
  ptbm_cmd_t   cmd;
  ptbm_stat_t  stat;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = paddr[3] ? 64'h0 : {16'b0, table_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
    end else if (cfg_we && !paddr[3]) begin
      table_base <= pwdata[47:0];
    end
  end

  ptbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptbm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .table_base     (table_base),
    .in_cmd         (req.cmd),
    .in_virt_addr   (req.virt_addr),
    .in_phys_addr   (req.phys_addr),
    .in_block_count (req.block_count),
    .in_attributes  (req.attributes),
    .in_read_page   (req.read_page),
    .in_read_slot   (req.read_slot),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_status     (rsp.status),
    .out_entry_data (rsp.entry_data),
    .out_pages_used (rsp.pages_used)
  );

endmodule

@@ sv/ptbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptbm_ctrl
// sequencer for reset clear, entry reads, table walks, page allocation, block writes
// ----------------------------------------------------------------------------
module ptbm_ctrl import ptbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  ptbm_stat_t stat,
  output ptbm_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = SC_OK;
    req_ready  = 1'b0;
    case (state)
      ST_RST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.is_read) begin
          cmd.rd_entry = 1'b1;
          state_next   = ST_RD_DATA;
        end else if (stat.va_mis) begin
          cmd.set_status = 1'b1;
          cmd.code       = SC_VA_MISALIGN;
          state_next     = ST_FINISH;
        end else if (stat.pa_mis) begin
          cmd.set_status = 1'b1;
          cmd.code       = SC_PA_MISALIGN;
          state_next     = ST_FINISH;
        end else if (stat.run_empty) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_WALK_RD;
        end
      end
      ST_RD_DATA: begin
        cmd.set_read_data = 1'b1;
        state_next        = ST_FINISH;
      end
      ST_WALK_RD: begin
        cmd.rd_walk = 1'b1;
        state_next  = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (!stat.ent_valid) begin
          if (stat.store_full) begin
            cmd.set_status = 1'b1;
            cmd.code       = SC_NO_PAGE;
            state_next     = ST_FINISH;
          end else begin
            cmd.alloc_start = 1'b1;
            state_next      = ST_ALLOC_CLR;
          end
        end else if (!stat.ent_table || !stat.next_ok) begin
          cmd.set_status = 1'b1;
          cmd.code       = SC_CONFLICT;
          state_next     = ST_FINISH;
        end else begin
          cmd.descend_rd = 1'b1;
          state_next     = stat.at_level1 ? ST_BLK_WR : ST_WALK_RD;
        end
      end
      ST_ALLOC_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_ALLOC_LINK;
        end
      end
      ST_ALLOC_LINK: begin
        cmd.link_wr      = 1'b1;
        cmd.descend_link = 1'b1;
        state_next       = stat.at_level1 ? ST_BLK_WR : ST_WALK_RD;
      end
      ST_BLK_WR: begin
        cmd.blk_wr = 1'b1;
        state_next = stat.run_last ? ST_FINISH : ST_WALK_RD;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ptbm_datapath.sv @@
// ----------------------------------------------------------------------------
// ptbm_datapath
// table store, walk registers, allocator, descriptor build and result word
// ----------------------------------------------------------------------------
module ptbm_datapath import ptbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ptbm_cmd_t   cmd,
  output ptbm_stat_t  stat,
  input  logic [47:0] table_base,
  input  logic        in_cmd,
  input  logic [47:0] in_virt_addr,
  input  logic [47:0] in_phys_addr,
  input  logic [9:0]  in_block_count,
  input  logic [63:0] in_attributes,
  input  logic [4:0]  in_read_page,
  input  logic [8:0]  in_read_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_entry_data,
  output logic [5:0]  out_pages_used
);

  logic [63:0] mem [0:NUM_PAGES*SLOTS-1];
  logic [63:0] rd_data;

  logic              is_read;
  logic [VA_W-1:0]   va;
  logic [VA_W-1:0]   pa;
  logic [63:0]       attr;
  logic [CNT_W-1:0]  remaining;
  logic [4:0]        rd_page;
  logic [8:0]        rd_slot;
  logic              level;
  logic [PAGE_W-1:0] cur;
  logic [PAGES_W-1:0] pages_in_use;
  logic [PAGE_W-1:0] clr_page;
  logic [SLOT_W-1:0] clr_cnt;
  logic [2:0]        status;
  logic [63:0]       data;

  logic [SLOT_W-1:0] walk_idx;
  logic [OA_W-1:0]   next_diff;
  logic [OA_W-1:0]   link_oa;
  logic [63:0]       link_desc;
  logic [63:0]       blk_desc;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [63:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CNT_W-1:0]  count_sat;

  assign walk_idx  = level ? va[38:30] : va[47:39];
  assign next_diff = rd_data[47:12] - table_base[47:12];
  assign link_oa   = table_base[47:12] + OA_W'(clr_page);
  assign link_desc = {16'b0, link_oa, 12'h003};
  assign blk_desc  = {16'b0, pa} | (attr & ATTR_MASK) | 64'h1;
  assign count_sat = (32'(in_block_count) > MAX_RUN) ? CNT_W'(MAX_RUN) : in_block_count;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur, walk_idx};
    mem_wdata = '0;
    if (cmd.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {clr_page, clr_cnt};
    end else if (cmd.link_wr) begin
      mem_we    = 1'b1;
      mem_wdata = link_desc;
    end else if (cmd.blk_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {cur, va[29:21]};
      mem_wdata = blk_desc;
    end
  end

  assign mem_re    = cmd.rd_entry | cmd.rd_walk;
  assign mem_raddr = cmd.rd_entry ? {PAGE_W'(rd_page), SLOT_W'(rd_slot)} : {cur, walk_idx};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read   <= (in_cmd == CMD_READ);
      va        <= in_virt_addr;
      pa        <= in_phys_addr;
      attr      <= in_attributes;
      remaining <= count_sat;
      rd_page   <= in_read_page;
      rd_slot   <= in_read_slot;
      status    <= SC_OK;
      data      <= '0;
    end
    if (cmd.set_status) begin
      status <= cmd.code;
    end
    if (cmd.set_read_data) begin
      data <= (32'(rd_page) < NUM_PAGES) ? rd_data : 64'h0;
    end
    if (cmd.blk_wr) begin
      va        <= va + STEP_2M;
      pa        <= pa + STEP_2M;
      remaining <= remaining - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= 1'b0;
      cur          <= '0;
      pages_in_use <= PAGES_W'(1);
      clr_page     <= '0;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.load || cmd.blk_wr) begin
        level <= 1'b0;
        cur   <= '0;
      end else if (cmd.descend_rd) begin
        level <= 1'b1;
        cur   <= next_diff[PAGE_W-1:0];
      end else if (cmd.descend_link) begin
        level <= 1'b1;
        cur   <= clr_page;
      end
      if (cmd.alloc_start) begin
        clr_page     <= pages_in_use[PAGE_W-1:0];
        clr_cnt      <= '0;
        pages_in_use <= pages_in_use + PAGES_W'(1);
      end else if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status     <= status;
      out_entry_data <= data;
      out_pages_used <= 6'(pages_in_use);
    end
  end

  always_comb begin
    stat.is_read    = is_read;
    stat.va_mis     = |va[20:0];
    stat.pa_mis     = |pa[20:0];
    stat.run_empty  = (remaining == '0);
    stat.ent_valid  = rd_data[0];
    stat.ent_table  = rd_data[1];
    stat.next_ok    = (next_diff < OA_W'(pages_in_use));
    stat.at_level1  = level;
    stat.store_full = (32'(pages_in_use) >= NUM_PAGES);
    stat.clr_last   = (clr_cnt == SLOT_W'(SLOTS - 1));
    stat.run_last   = (remaining == CNT_W'(1));
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

@@ verif/page_table_2m_block_mapper_chk.sv @@
// ----------------------------------------------------------------------------
// page_table_2m_block_mapper_chk
// Watches the command, result and APB channels of the 2M block table mapper.
// Keeps its own copy of the table store, the page count and table_base, works
// out the result word of every accepted command and compares each returned
// word field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module page_table_2m_block_mapper_chk import ptbm_pkg::*; #(
  parameter logic [3:0] BASE_REG_ADDR = 4'h0
) (
  input  logic        clk,
  input  logic        rst,
  ptbm_req_if         req,
  ptbm_rsp_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output int unsigned mismatches,
  output int unsigned pages_now,
  output int unsigned owed
);

  localparam logic [47:0] OA_MASK48 = 48'hffff_ffff_f000;

  typedef struct packed {
    stat_code_t  status;
    logic [63:0] entry_data;
    logic [5:0]  pages_used;
  } result_word_t;

  logic [63:0]  store_words [0:NUM_PAGES*SLOTS-1];
  int unsigned  page_count;
  logic [47:0]  base_reg;
  result_word_t due_words [$];
  int unsigned  fails;

  function automatic logic [47:0] page_location(int unsigned p);
    return ((base_reg & OA_MASK48) + (48'(p) << 12)) & OA_MASK48;
  endfunction

  // walk levels 0 and 1, allocating tables as needed, then write the block
  function automatic stat_code_t map_block_at(logic [47:0] va, logic [47:0] pa,
                                              logic [63:0] attr);
    int unsigned cur;
    int unsigned idx;
    int unsigned fresh;
    int unsigned lvl;
    int unsigned s;
    logic [63:0] ent;
    logic [47:0] off;
    cur = 0;
    for (lvl = 0; lvl < 2; lvl++) begin
      idx = (lvl == 0) ? va[47:39] : va[38:30];
      ent = store_words[cur*SLOTS + idx];
      if (!ent[0]) begin
        if (page_count >= NUM_PAGES) return SC_NO_PAGE;
        fresh = page_count;
        page_count++;
        for (s = 0; s < SLOTS; s++) store_words[fresh*SLOTS + s] = '0;
        ent = {16'h0, page_location(fresh)} | 64'h3;
        store_words[cur*SLOTS + idx] = ent;
      end
      if (!ent[1]) return SC_CONFLICT;
      off = (ent[47:0] & OA_MASK48) - (base_reg & OA_MASK48);
      if (off[47:12] >= page_count) return SC_CONFLICT;
      cur = off[47:12];
    end
    store_words[cur*SLOTS + va[29:21]] = {16'h0, pa} | (attr & ATTR_MASK) | 64'h1;
    return SC_OK;
  endfunction

  function automatic result_word_t run_command(logic c, logic [47:0] va,
                                               logic [47:0] pa, logic [9:0] cnt,
                                               logic [63:0] attr, logic [4:0] pg,
                                               logic [8:0] sl);
    result_word_t r;
    int unsigned  n;
    int unsigned  i;
    stat_code_t   st;
    r.status     = SC_OK;
    r.entry_data = '0;
    if (c == CMD_READ) begin
      r.entry_data = store_words[pg*SLOTS + sl];
    end else if (va[20:0] != '0) begin
      r.status = SC_VA_MISALIGN;
    end else if (pa[20:0] != '0) begin
      r.status = SC_PA_MISALIGN;
    end else begin
      n = (cnt > MAX_RUN) ? MAX_RUN : cnt;
      for (i = 0; i < n; i++) begin
        st = map_block_at(va, pa, attr);
        va = va + STEP_2M;
        pa = pa + STEP_2M;
        if (st != SC_OK) begin
          r.status = st;
          break;
        end
      end
    end
    r.pages_used = 6'(page_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_word_t want;
    int unsigned  k;
    if (rst) begin
      for (k = 0; k < NUM_PAGES*SLOTS; k++) store_words[k] = '0;
      page_count = 1;
      base_reg   = '0;
      fails      = 0;
      due_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == BASE_REG_ADDR)
        base_reg = pwdata[47:0];
      if (rsp.valid && rsp.ready) begin
        if (due_words.size() == 0) begin
          $error("result word with none due: status %0d entry_data %h pages_used %0d",
                 rsp.status, rsp.entry_data, rsp.pages_used);
          fails++;
        end else begin
          want = due_words.pop_front();
          if (rsp.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp.status);
            fails++;
          end
          if (rsp.entry_data !== want.entry_data) begin
            $error("entry_data expected %h actual %h", want.entry_data, rsp.entry_data);
            fails++;
          end
          if (rsp.pages_used !== want.pages_used) begin
            $error("pages_used expected %0d actual %0d", want.pages_used, rsp.pages_used);
            fails++;
          end
        end
      end
      if (req.valid && req.ready)
        due_words.push_back(run_command(req.cmd, req.virt_addr, req.phys_addr,
                                        req.block_count, req.attributes,
                                        req.read_page, req.read_slot));
    end
    mismatches <= fails;
    pages_now  <= page_count;
    owed       <= due_words.size();
  end

endmodule

@@ verif/page_table_2m_block_mapper_core_tb.sv @@
// ----------------------------------------------------------------------------
// page_table_2m_block_mapper_core_tb
// Drives map and read commands into the table mapper with random gaps and
// result stalls, under four table_base settings (top of range, zero, a few
// pages below the top, top again). A directed opening covers misalignment,
// empty and saturated runs, address wrap and readback; random runs reuse a
// small set of regions so the store fills and stale tables get walked.
// ----------------------------------------------------------------------------
module page_table_2m_block_mapper_core_tb;
  import ptbm_pkg::*;

  localparam logic [3:0]  BASE_REG_ADDR = 4'h0;
  localparam logic [47:0] BASE_TOP      = 48'hffff_ffff_ffff;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pages_now;
  int unsigned owed;
  int unsigned sent;
  int unsigned rsp_words;
  int unsigned n_maps;
  int unsigned n_reads;
  bit          send_calm;
  bit          rcv_calm;
  int unsigned rcv_hold;
  logic [8:0]  l0_pool [4];
  logic [8:0]  l1_pool [4];

  ptbm_req_if req_ch ();
  ptbm_rsp_if rsp_ch ();

  always #10 clk = ~clk;

  page_table_2m_block_mapper_core u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  page_table_2m_block_mapper_chk #(.BASE_REG_ADDR(BASE_REG_ADDR)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pages_now  (pages_now),
    .owed       (owed)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result side: random stall before each word, calm stretches without stalls
  always @(posedge clk) begin : result_side
    int unsigned nxt;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rcv_hold     <= 0;
      rsp_words    <= 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if ($urandom_range(0, 23) == 0) rcv_calm = !rcv_calm;
      nxt = rcv_calm ? 0 : $urandom_range(0, 16);
      rsp_words    <= rsp_words + 1;
      rcv_hold     <= nxt;
      rsp_ch.ready <= (nxt == 0);
    end else if (rcv_hold != 0) begin
      rcv_hold     <= rcv_hold - 1;
      rsp_ch.ready <= (rcv_hold == 1);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic apb_write(input logic [47:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BASE_REG_ADDR;
    pwdata  <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic issue(input cmd_code_t c, input logic [47:0] va, input logic [47:0] pa,
                       input logic [9:0] cnt, input logic [63:0] attr,
                       input logic [4:0] pg, input logic [8:0] sl);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= c;
    req_ch.virt_addr   <= va;
    req_ch.phys_addr   <= pa;
    req_ch.block_count <= cnt;
    req_ch.attributes  <= attr;
    req_ch.read_page   <= pg;
    req_ch.read_slot   <= sl;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_map(input logic [47:0] va, input logic [47:0] pa,
                          input logic [9:0] cnt, input logic [63:0] attr);
    n_maps++;
    issue(CMD_MAP, va, pa, cnt, attr, 5'($urandom), 9'($urandom));
  endtask

  task automatic send_read(input logic [4:0] pg, input logic [8:0] sl);
    n_reads++;
    issue(CMD_READ, 48'(rand64()), 48'(rand64()), 10'($urandom), rand64(), pg, sl);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (rsp_words != sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_word();
    logic [8:0]  l0;
    logic [8:0]  l1;
    logic [8:0]  l2;
    logic [8:0]  sl;
    logic [47:0] va;
    logic [47:0] pa;
    logic [9:0]  cnt;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      sl = $urandom_range(0, 1) ? 9'($urandom)
                                : (($urandom_range(0, 1) == 0) ? l0_pool[$urandom_range(0, 3)]
                                                               : 9'($urandom_range(0, 3)));
      send_read(5'($urandom_range(0, pages_now - 1)), sl);
    end else begin
      l0  = ($urandom_range(0, 7) == 0) ? 9'($urandom) : l0_pool[$urandom_range(0, 3)];
      l1  = ($urandom_range(0, 7) == 0) ? 9'($urandom) : l1_pool[$urandom_range(0, 3)];
      l2  = $urandom_range(0, 1) ? 9'($urandom) : 9'($urandom_range(0, 3));
      va  = {l0, l1, l2, 21'h0};
      pa  = 48'(rand64()) & ~48'h1f_ffff;
      if (roll < 32) va[20:0] = 21'($urandom_range(1, 21'h1f_ffff));
      else if (roll < 38) pa[20:0] = 21'($urandom_range(1, 21'h1f_ffff));
      roll = $urandom_range(0, 99);
      if (roll < 5) cnt = 10'd0;
      else if (roll < 10) cnt = 10'($urandom_range(500, 1023));
      else if (roll < 30) cnt = 10'($urandom_range(5, 40));
      else cnt = 10'($urandom_range(1, 4));
      send_map(va, pa, cnt, rand64());
    end
  endtask

  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_MAP;
    req_ch.virt_addr   <= '0;
    req_ch.phys_addr   <= '0;
    req_ch.block_count <= '0;
    req_ch.attributes  <= '0;
    req_ch.read_page   <= '0;
    req_ch.read_slot   <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    sent      = 0;
    n_maps    = 0;
    n_reads   = 0;
    send_calm = 1'b0;
    rcv_calm  = 1'b0;
    l0_pool   = '{9'd0, 9'd511, 9'd2, 9'($urandom)};
    l1_pool   = '{9'd0, 9'd511, 9'd1, 9'($urandom)};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apb_write(BASE_TOP);

    // directed opening
    send_read(5'd0, 9'd0);
    send_read(5'd0, 9'd511);
    send_map(48'h0000_0000_0001, 48'h0000_0000_0001, 10'd0, '1);
    send_map(48'h0000_0020_0000, 48'h0000_001f_ffff, 10'd3, '1);
    send_map(48'h0000_0040_0000, 48'h0000_0040_0000, 10'd0, '1);
    send_map(48'h0000_0000_0000, 48'h0000_0000_0000, 10'd1, 64'h0);
    send_map(48'hffff_ffe0_0000, 48'hffff_ffe0_0000, 10'd2, '1);
    send_read(5'd0, 9'd511);
    send_read(5'd0, 9'd0);
    send_read(5'd1, 9'd0);
    send_read(5'd2, 9'd0);
    send_read(5'd3, 9'd511);
    send_read(5'd4, 9'd511);
    send_map(48'h0000_4000_0000, 48'h1234_5660_0000, 10'd1023, rand64());
    send_map(48'h0100_0000_0000, 48'h0000_0000_0000, 10'd512, rand64());
    send_map(48'h0000_8000_0000, 48'hffff_ffe0_0000, 10'd1, 64'h0);
    send_read(5'd5, 9'd0);
    send_read(5'd5, 9'd511);

    repeat (120) random_word();
    drain();
    apb_write(48'h0);
    repeat (40) random_word();
    drain();
    apb_write(((BASE_TOP & 48'hffff_ffff_f000) - (48'($urandom_range(1, 4)) << 12))
              | 48'($urandom_range(0, 12'hfff)));
    repeat (30) random_word();
    drain();
    apb_write(BASE_TOP);
    repeat (100) random_word();
    drain();
    repeat (20) @(posedge clk);

    if (owed != 0) $error("%0d result words never arrived", owed);
    $display("run covered %0d map and %0d read words over four table_base settings,",
             n_maps, n_reads);
    $display("ending with %0d of %0d table pages in use", pages_now, NUM_PAGES);
    if (mismatches == 0 && owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
